// ===== src/bfld_pkg.sv =====
`default_nettype none

package bfld_pkg;

    // Number of landmarks and decoded coordinates (x and y for each landmark).
    localparam int NUM_POINTS = 5;
    localparam int NUM_COORDS = 2 * NUM_POINTS;
    localparam int PT_W       = (NUM_POINTS > 1) ? $clog2(NUM_POINTS) : 1;
    localparam int CNT_W      = PT_W + 1;

    // Configuration port.
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_ADDR_W-1:0] REG_IMAGE_WIDTH       = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_IMAGE_HEIGHT      = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_LANDMARK_VARIANCE = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_SCORE_THRESHOLD   = 2'd3;

    localparam logic [12:0] IMAGE_WIDTH_RST  = 13'd320;
    localparam logic [12:0] IMAGE_HEIGHT_RST = 13'd320;
    localparam logic [15:0] VARIANCE_RST     = 16'd6554;
    localparam logic [15:0] THRESHOLD_RST    = 16'd355;

    // Half of one Q16.4 step at the 2^-44 * pixel scale of the decode sum.
    localparam logic signed [63:0] ROUND_BIAS = 64'sd549755813888;

    localparam logic [19:0] PT_MAX = 20'h7FFFF;
    localparam logic [19:0] PT_MIN = 20'h80000;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PRE1,
        ST_PRE2,
        ST_DECODE,
        ST_DRAIN,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic             accept;
        logic             pre1;
        logic             pre2;
        logic             mul_en;
        logic [CNT_W-1:0] mul_idx;
        logic             wr_en;
        logic [CNT_W-1:0] wr_idx;
        logic             emit;
    } t_cmd;

    typedef struct packed {
        logic win;
        logic out_free;
    } t_status;

endpackage

`default_nettype wire

// ===== src/bfld_ctrl.sv =====
`default_nettype none

module bfld_ctrl (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_ready,
    input  wire                 i_last_of_frame,
    input  bfld_pkg::t_status   i_status,
    output bfld_pkg::t_cmd      o_cmd
);

    bfld_pkg::t_state                r_state, n_state;
    logic [bfld_pkg::CNT_W-1:0]      r_cnt, n_cnt;
    logic                            r_last, n_last;
    logic                            r_wr_en;
    logic [bfld_pkg::CNT_W-1:0]      r_wr_idx;
    logic                            w_accept;

    assign o_in_ready = (r_state == bfld_pkg::ST_IDLE);
    assign w_accept   = i_in_valid & o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= bfld_pkg::ST_IDLE;
            r_cnt    <= '0;
            r_last   <= 1'b0;
            r_wr_en  <= 1'b0;
            r_wr_idx <= '0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_last   <= n_last;
            r_wr_en  <= o_cmd.mul_en;
            r_wr_idx <= o_cmd.mul_idx;
        end
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_last  = r_last;
        o_cmd   = '0;
        o_cmd.accept = w_accept;
        o_cmd.wr_en  = r_wr_en;
        o_cmd.wr_idx = r_wr_idx;
        case (r_state)
            bfld_pkg::ST_IDLE: begin
                if (w_accept) begin
                    n_last = i_last_of_frame;
                    if (i_status.win) begin
                        n_state = bfld_pkg::ST_PRE1;
                    end else if (i_last_of_frame) begin
                        n_state = bfld_pkg::ST_EMIT;
                    end
                end
            end
            bfld_pkg::ST_PRE1: begin
                o_cmd.pre1 = 1'b1;
                n_state    = bfld_pkg::ST_PRE2;
            end
            bfld_pkg::ST_PRE2: begin
                o_cmd.pre2 = 1'b1;
                n_cnt      = '0;
                n_state    = bfld_pkg::ST_DECODE;
            end
            bfld_pkg::ST_DECODE: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_idx = r_cnt;
                n_cnt         = r_cnt + 1'b1;
                if (r_cnt == bfld_pkg::CNT_W'(bfld_pkg::NUM_COORDS - 1)) begin
                    n_state = bfld_pkg::ST_DRAIN;
                end
            end
            bfld_pkg::ST_DRAIN: begin
                n_state = r_last ? bfld_pkg::ST_EMIT : bfld_pkg::ST_IDLE;
            end
            bfld_pkg::ST_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = bfld_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = bfld_pkg::ST_IDLE;
            end
        endcase
    end

    // A winning location always starts the decode sequence.
    a_win_starts_decode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_status.win) |=> (r_state == bfld_pkg::ST_PRE1))
        else $error("winning location did not start decode");

    // The coordinate counter never runs past the last coordinate while decoding.
    a_cnt_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == bfld_pkg::ST_DECODE) |->
        (r_cnt <= bfld_pkg::CNT_W'(bfld_pkg::NUM_COORDS - 1)))
        else $error("coordinate counter out of range");

    // Every coordinate write follows a multiply issued in the previous cycle.
    a_wr_after_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.wr_en |-> $past(o_cmd.mul_en))
        else $error("coordinate write without a prior multiply");

    // Emission returns the controller to idle.
    a_emit_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |=> (r_state == bfld_pkg::ST_IDLE))
        else $error("emit did not return to idle");

endmodule

`default_nettype wire

// ===== src/bfld_dp.sv =====
`default_nettype none

module bfld_dp (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  i_cfg_we,
    input  wire  [bfld_pkg::CFG_ADDR_W-1:0]      i_cfg_addr,
    input  wire  [bfld_pkg::CFG_DATA_W-1:0]      i_cfg_wdata,
    input  wire  signed [15:0]                   i_logit_background,
    input  wire  signed [15:0]                   i_logit_face,
    input  wire  [16:0]                          i_anchor_center_x,
    input  wire  [16:0]                          i_anchor_center_y,
    input  wire  [16:0]                          i_anchor_width,
    input  wire  [16:0]                          i_anchor_height,
    input  wire  [31:0]                          i_offset_point0,
    input  wire  [31:0]                          i_offset_point1,
    input  wire  [31:0]                          i_offset_point2,
    input  wire  [31:0]                          i_offset_point3,
    input  wire  [31:0]                          i_offset_point4,
    input  bfld_pkg::t_cmd                       i_cmd,
    output bfld_pkg::t_status                    o_status,
    output logic                                 o_out_valid,
    input  wire                                  i_out_ready,
    output logic                                 o_face_found,
    output logic [19:0]                          o_pts [bfld_pkg::NUM_COORDS]
);

    // Configuration registers.
    logic [12:0]        r_img_w;
    logic [12:0]        r_img_h;
    logic [15:0]        r_var;
    logic [15:0]        r_thr;

    // Frame state.
    logic signed [16:0] r_best_diff;
    logic               r_found;
    logic               r_frame_open;
    logic               r_out_valid;

    // Latched location.
    logic [16:0]        r_acx, r_acy, r_aw, r_ah;
    logic [31:0]        r_off [bfld_pkg::NUM_POINTS];
    logic [31:0]        w_off_in [bfld_pkg::NUM_POINTS];

    // Per-axis factors shared by all landmarks of one location.
    logic [32:0]        r_vs_x, r_vs_y;
    logic [29:0]        r_ci_x, r_ci_y;
    logic [45:0]        r_k_x, r_k_y;

    // Product stage of the coordinate pipeline.
    logic signed [39:0] r_plo, r_phi;
    logic [29:0]        r_pc;

    logic [19:0]        r_pts [bfld_pkg::NUM_COORDS];
    logic [19:0]        r_out_pts [bfld_pkg::NUM_COORDS];
    logic               r_out_found;

    logic signed [16:0] w_diff, w_thr, w_eff;
    logic               w_win;
    logic               w_axis;
    logic [bfld_pkg::PT_W-1:0] w_pt;
    logic [31:0]        w_pair;
    logic signed [15:0] w_ofs;
    logic [45:0]        w_k;
    logic signed [63:0] w_cterm, w_hterm, w_lterm, w_t;
    logic signed [23:0] w_q;
    logic [19:0]        w_sat;

    assign w_off_in[0] = i_offset_point0;
    assign w_off_in[1] = i_offset_point1;
    assign w_off_in[2] = i_offset_point2;
    assign w_off_in[3] = i_offset_point3;
    assign w_off_in[4] = i_offset_point4;

    // Score test on the logit difference against the kept best, or against the
    // threshold when this item opens a new frame.
    assign w_diff = {i_logit_face[15], i_logit_face}
                  - {i_logit_background[15], i_logit_background};
    assign w_thr  = {r_thr[15], r_thr};
    assign w_eff  = r_frame_open ? r_best_diff : w_thr;
    assign w_win  = w_diff > w_eff;

    assign o_status.win      = w_win;
    assign o_status.out_free = !r_out_valid || i_out_ready;

    // Coordinate selection: even indices are x, odd indices are y.
    assign w_axis = i_cmd.mul_idx[0];
    assign w_pt   = i_cmd.mul_idx[bfld_pkg::CNT_W-1:1];
    assign w_pair = r_off[w_pt];
    assign w_ofs  = w_axis ? w_pair[31:16] : w_pair[15:0];
    assign w_k    = w_axis ? r_k_y : r_k_x;

    // Final sum and round to nearest Q16.4, then saturate.
    assign w_cterm = {6'd0, r_pc, 28'd0};
    assign w_hterm = {r_phi[39], r_phi, 23'd0};
    assign w_lterm = {{24{r_plo[39]}}, r_plo};
    assign w_t     = w_cterm + w_hterm + w_lterm + bfld_pkg::ROUND_BIAS;
    assign w_q     = w_t[63:40];

    always_comb begin
        if ((w_q[23:19] == 5'b00000) || (w_q[23:19] == 5'b11111)) begin
            w_sat = w_q[19:0];
        end else begin
            w_sat = w_q[23] ? bfld_pkg::PT_MIN : bfld_pkg::PT_MAX;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_img_w      <= bfld_pkg::IMAGE_WIDTH_RST;
            r_img_h      <= bfld_pkg::IMAGE_HEIGHT_RST;
            r_var        <= bfld_pkg::VARIANCE_RST;
            r_thr        <= bfld_pkg::THRESHOLD_RST;
            r_best_diff  <= {bfld_pkg::THRESHOLD_RST[15], bfld_pkg::THRESHOLD_RST};
            r_found      <= 1'b0;
            r_frame_open <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    bfld_pkg::REG_IMAGE_WIDTH:       r_img_w <= i_cfg_wdata[12:0];
                    bfld_pkg::REG_IMAGE_HEIGHT:      r_img_h <= i_cfg_wdata[12:0];
                    bfld_pkg::REG_LANDMARK_VARIANCE: r_var   <= i_cfg_wdata;
                    bfld_pkg::REG_SCORE_THRESHOLD:   r_thr   <= i_cfg_wdata;
                    default: begin
                    end
                endcase
            end
            if (i_cmd.accept) begin
                r_best_diff  <= w_win ? w_diff : w_eff;
                r_found      <= w_win || (r_frame_open && r_found);
                r_frame_open <= 1'b1;
            end else if (i_cmd.emit) begin
                r_frame_open <= 1'b0;
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_acx <= i_anchor_center_x;
            r_acy <= i_anchor_center_y;
            r_aw  <= i_anchor_width;
            r_ah  <= i_anchor_height;
            for (int p = 0; p < bfld_pkg::NUM_POINTS; p++) begin
                r_off[p] <= w_off_in[p];
            end
        end
        if (i_cmd.pre1) begin
            r_vs_x <= {17'd0, r_var} * {16'd0, r_aw};
            r_vs_y <= {17'd0, r_var} * {16'd0, r_ah};
            r_ci_x <= {17'd0, r_img_w} * {13'd0, r_acx};
            r_ci_y <= {17'd0, r_img_h} * {13'd0, r_acy};
        end
        if (i_cmd.pre2) begin
            r_k_x <= {13'd0, r_vs_x} * {33'd0, r_img_w};
            r_k_y <= {13'd0, r_vs_y} * {33'd0, r_img_h};
        end
        if (i_cmd.mul_en) begin
            r_plo <= w_ofs * $signed({1'b0, w_k[22:0]});
            r_phi <= w_ofs * $signed({1'b0, w_k[45:23]});
            r_pc  <= w_axis ? r_ci_y : r_ci_x;
        end
        if (i_cmd.accept && !r_frame_open) begin
            for (int c = 0; c < bfld_pkg::NUM_COORDS; c++) begin
                r_pts[c] <= '0;
            end
        end else if (i_cmd.wr_en) begin
            r_pts[i_cmd.wr_idx] <= w_sat;
        end
        if (i_cmd.emit) begin
            r_out_found <= r_found;
            for (int c = 0; c < bfld_pkg::NUM_COORDS; c++) begin
                r_out_pts[c] <= r_pts[c];
            end
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_face_found = r_out_found;
    assign o_pts        = r_out_pts;

    // A held result stays valid until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |=> r_out_valid)
        else $error("result dropped before it was taken");

    // Only an open frame can have a found flag set by an accepted winner.
    a_win_sets_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.accept && w_win) |=> (r_found && r_frame_open))
        else $error("winner did not set the found flag");

    // Emission never overwrites a result that is still waiting.
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> (!r_out_valid || i_out_ready))
        else $error("emit overwrote a pending result");

endmodule

`default_nettype wire

// ===== src/best_face_landmark_decoder_top.sv =====
// A location that is not a new best is taken at once; a new best then steps through the
// setup states PRE1 and PRE2, ten coordinate multiplies and one write drain.
// A frame's last location then passes the emit state, which waits while the previous
// result is still held, before its result is valid. Throughput: 1 location per cycle
// while no new best occurs and no frame ends; a new best stalls input during its decode.
// Reset: synchronous active-low; registers return to defaults, no frame is open.
`default_nettype none

module best_face_landmark_decoder_top (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    // Configuration write port.
    input  wire                                  i_cfg_we,
    input  wire  [bfld_pkg::CFG_ADDR_W-1:0]      i_cfg_addr,
    input  wire  [bfld_pkg::CFG_DATA_W-1:0]      i_cfg_wdata,
    // Location request channel.
    input  wire                                  i_in_valid,
    output logic                                 o_in_ready,
    input  wire  signed [15:0]                   i_logit_background,
    input  wire  signed [15:0]                   i_logit_face,
    input  wire  [16:0]                          i_anchor_center_x,
    input  wire  [16:0]                          i_anchor_center_y,
    input  wire  [16:0]                          i_anchor_width,
    input  wire  [16:0]                          i_anchor_height,
    input  wire  [31:0]                          i_offset_point0,
    input  wire  [31:0]                          i_offset_point1,
    input  wire  [31:0]                          i_offset_point2,
    input  wire  [31:0]                          i_offset_point3,
    input  wire  [31:0]                          i_offset_point4,
    input  wire                                  i_last_of_frame,
    // Result request channel.
    output logic                                 o_out_valid,
    input  wire                                  i_out_ready,
    output logic                                 o_face_found,
    output logic signed [19:0]                   o_point0_x,
    output logic signed [19:0]                   o_point0_y,
    output logic signed [19:0]                   o_point1_x,
    output logic signed [19:0]                   o_point1_y,
    output logic signed [19:0]                   o_point2_x,
    output logic signed [19:0]                   o_point2_y,
    output logic signed [19:0]                   o_point3_x,
    output logic signed [19:0]                   o_point3_y,
    output logic signed [19:0]                   o_point4_x,
    output logic signed [19:0]                   o_point4_y
);

    // The controller sequences each accepted location: it compares the logit
    // difference in the accept cycle, and only when the location beats the kept
    // best does it walk the datapath through the decode of all coordinates.
    bfld_pkg::t_cmd    w_cmd;
    bfld_pkg::t_status w_status;
    logic [19:0]       w_pts [bfld_pkg::NUM_COORDS];

    bfld_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_last_of_frame (i_last_of_frame),
        .i_status        (w_status),
        .o_cmd           (w_cmd)
    );

    // The datapath holds the configuration, the frame's best score and points,
    // the shared multipliers and the output register. The output register lets
    // the next frame start while a finished result still waits to be taken.
    bfld_dp u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_addr         (i_cfg_addr),
        .i_cfg_wdata        (i_cfg_wdata),
        .i_logit_background (i_logit_background),
        .i_logit_face       (i_logit_face),
        .i_anchor_center_x  (i_anchor_center_x),
        .i_anchor_center_y  (i_anchor_center_y),
        .i_anchor_width     (i_anchor_width),
        .i_anchor_height    (i_anchor_height),
        .i_offset_point0    (i_offset_point0),
        .i_offset_point1    (i_offset_point1),
        .i_offset_point2    (i_offset_point2),
        .i_offset_point3    (i_offset_point3),
        .i_offset_point4    (i_offset_point4),
        .i_cmd              (w_cmd),
        .o_status           (w_status),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_face_found       (o_face_found),
        .o_pts              (w_pts)
    );

    // Coordinates are stored x then y for each landmark.
    assign o_point0_x = w_pts[0];
    assign o_point0_y = w_pts[1];
    assign o_point1_x = w_pts[2];
    assign o_point1_y = w_pts[3];
    assign o_point2_x = w_pts[4];
    assign o_point2_y = w_pts[5];
    assign o_point3_x = w_pts[6];
    assign o_point3_y = w_pts[7];
    assign o_point4_x = w_pts[8];
    assign o_point4_y = w_pts[9];

endmodule

`default_nettype wire
